### hw/rtl/cpio_bme_pkg.sv
// shared types and constants for the binary cpio member extractor
`timescale 1ns / 1ps

package cpio_bme_pkg;

    // input command codes
    localparam logic CMD_NAME    = 1'b0;
    localparam logic CMD_ARCHIVE = 1'b1;

    // result kind codes
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // parser phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_NAME   = 3'd1;
    localparam logic [2:0] PH_PAD    = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;
    localparam logic [2:0] PH_ERROR  = 3'd6;

    // header layout
    localparam logic [4:0]  HEADER_LAST = 5'd25;
    localparam logic [15:0] CPIO_MAGIC  = 16'h71C7;

    // one result beat
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last;
    } t_result;

endpackage

### hw/rtl/cpio_bme_if.sv
// valid/ready channel interfaces for the cpio member extractor
`timescale 1ns / 1ps

// input item channel
interface cpio_bme_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [6:0] name_index;
    logic [7:0] byte_value;

    modport source (output valid, command, name_index, byte_value, input ready);
    modport sink   (input valid, command, name_index, byte_value, output ready);
endinterface

// result channel
interface cpio_bme_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, kind, data_byte, last, input ready);
    modport sink   (input valid, kind, data_byte, last, output ready);
endinterface

// target length register write channel
interface cpio_bme_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/cpio_bme_name_ram.sv
// target name store with registered read and write-to-read bypass
`timescale 1ns / 1ps

module cpio_bme_name_ram #(
    parameter int NAME_MAX = 128
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [$clog2(NAME_MAX)-1:0] i_wr_addr,
    input  logic [7:0]                  i_wr_data,
    input  logic [$clog2(NAME_MAX)-1:0] i_rd_addr,
    output logic [7:0]                  o_rd_data
);

    logic [7:0] r_mem [NAME_MAX];
    logic [7:0] r_rd_data;

    // write port, and read port that sees a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/cpio_bme_out_buf.sv
// two-entry result buffer: output register plus skid register
`timescale 1ns / 1ps

module cpio_bme_out_buf
    import cpio_bme_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_ready,
    cpio_bme_out_if.source o_result
);

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    w_pop;

    assign w_pop   = r_main_v && o_result.ready;
    assign o_ready = !r_skid_v;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_v || w_pop) begin
                r_main_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_v <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_v || w_pop) begin
                r_main <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

    assign o_result.valid     = r_main_v;
    assign o_result.kind      = r_main.kind;
    assign o_result.data_byte = r_main.data_byte;
    assign o_result.last      = r_main.last;

endmodule

### hw/rtl/cpio_binary_member_extract_top.sv
// old binary cpio archive parser that extracts one named member
// a result beat is registered, via the skid register when the output one is full
// throughput: one input beat per cycle; the two-entry result buffer keeps input open
// while a result waits, and input stalls only when both result entries are full
// reset clears the parser state, counters and target length; the target name
// store is not cleared and must be loaded before it is compared
`timescale 1ns / 1ps

module cpio_binary_member_extract_top
    import cpio_bme_pkg::*;
#(
    parameter int NAME_MAX = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cpio_bme_in_if.sink    i_item,
    cpio_bme_cfg_if.sink   i_cfg,
    cpio_bme_out_if.source o_result
);

    localparam int AW = $clog2(NAME_MAX);

    // header byte positions
    localparam logic [4:0] HP_MAGIC_LO = 5'd0;
    localparam logic [4:0] HP_MAGIC_HI = 5'd1;
    localparam logic [4:0] HP_NSIZE_LO = 5'd20;
    localparam logic [4:0] HP_NSIZE_HI = 5'd21;
    localparam logic [4:0] HP_FSIZE_B2 = 5'd22;
    localparam logic [4:0] HP_FSIZE_B3 = 5'd23;
    localparam logic [4:0] HP_FSIZE_B0 = 5'd24;
    localparam logic [4:0] HP_FSIZE_B1 = 5'd25;

    logic [7:0]  r_target_length;
    logic [2:0]  r_phase,      n_phase;
    logic [4:0]  r_hcount,     n_hcount;
    logic [15:0] r_magic,      n_magic;
    logic [15:0] r_name_size,  n_name_size;
    logic [31:0] r_file_size,  n_file_size;
    logic [15:0] r_name_pos,   n_name_pos;
    logic        r_match,      n_match;
    logic [32:0] r_brem,       n_brem;

    logic          w_accept;
    logic          w_in_ready;
    logic          w_res_v;
    t_result       w_res;
    logic          w_finish;
    logic [7:0]    w_eff_len;
    logic [7:0]    w_tgt_char;
    logic [7:0]    w_byte;
    logic          w_wr_en;
    logic [32:0]   w_skip;

    assign w_accept = i_item.valid && i_item.ready;
    assign w_byte   = i_item.byte_value;
    assign i_item.ready = w_in_ready;
    assign i_cfg.ready  = 1'b1;

    // target length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_length <= 8'd0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_target_length <= i_cfg.data;
        end
    end

    // target length saturated to the store depth
    assign w_eff_len = (32'(r_target_length) > NAME_MAX) ? 8'(NAME_MAX) : r_target_length;

    // name character loads
    assign w_wr_en = w_accept && (i_item.command == CMD_NAME)
                     && (32'(i_item.name_index) < NAME_MAX);

    cpio_bme_name_ram #(
        .NAME_MAX (NAME_MAX)
    ) u_name_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(i_item.name_index)),
        .i_wr_data (w_byte),
        .i_rd_addr (AW'(n_name_pos)),
        .o_rd_data (w_tgt_char)
    );

    assign w_skip = {1'b0, n_file_size} + {32'd0, n_file_size[0]};

    // per-byte parser
    always_comb begin
        n_phase     = r_phase;
        n_hcount    = r_hcount;
        n_magic     = r_magic;
        n_name_size = r_name_size;
        n_file_size = r_file_size;
        n_name_pos  = r_name_pos;
        n_match     = r_match;
        n_brem      = r_brem;
        w_finish    = 1'b0;
        w_res_v     = 1'b0;
        w_res       = '0;

        if (w_accept && (i_item.command == CMD_ARCHIVE)) begin
            unique case (r_phase)
                PH_HEADER: begin
                    case (r_hcount)
                        HP_MAGIC_LO: n_magic[7:0]       = w_byte;
                        HP_MAGIC_HI: n_magic[15:8]      = w_byte;
                        HP_NSIZE_LO: n_name_size[7:0]   = w_byte;
                        HP_NSIZE_HI: n_name_size[15:8]  = w_byte;
                        HP_FSIZE_B2: n_file_size[23:16] = w_byte;
                        HP_FSIZE_B3: n_file_size[31:24] = w_byte;
                        HP_FSIZE_B0: n_file_size[7:0]   = w_byte;
                        HP_FSIZE_B1: n_file_size[15:8]  = w_byte;
                        default: ;
                    endcase
                    n_hcount = r_hcount + 5'd1;
                    if (r_hcount == HEADER_LAST) begin
                        n_hcount = 5'd0;
                        if (n_magic != CPIO_MAGIC) begin
                            n_phase         = PH_ERROR;
                            w_res_v         = 1'b1;
                            w_res.kind      = KIND_ERROR;
                            w_res.last      = 1'b1;
                        end else begin
                            n_name_pos = 16'd0;
                            n_match    = 1'b1;
                            if (n_name_size == 16'd0) begin
                                w_finish = 1'b1;
                            end else begin
                                n_phase = PH_NAME;
                            end
                        end
                    end
                end
                PH_NAME: begin
                    if (r_name_pos < {8'd0, w_eff_len}) begin
                        if (w_byte != w_tgt_char) begin
                            n_match = 1'b0;
                        end
                    end else if (r_name_pos == {8'd0, w_eff_len}) begin
                        if (w_byte != 8'd0) begin
                            n_match = 1'b0;
                        end
                    end
                    n_name_pos = r_name_pos + 16'd1;
                    if (n_name_pos == r_name_size) begin
                        if (r_name_size[0]) begin
                            n_phase = PH_PAD;
                        end else begin
                            w_finish = 1'b1;
                        end
                    end
                end
                PH_PAD: begin
                    w_finish = 1'b1;
                end
                PH_SKIP: begin
                    n_brem = r_brem - 33'd1;
                    if (r_brem == 33'd1) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_DATA: begin
                    n_brem          = r_brem - 33'd1;
                    w_res_v         = 1'b1;
                    w_res.kind      = KIND_DATA;
                    w_res.data_byte = w_byte;
                    w_res.last      = (r_brem == 33'd1);
                    if (r_brem == 33'd1) begin
                        n_phase = PH_DONE;
                    end
                end
                default: ;
            endcase

            // end of name: match decision
            if (w_finish) begin
                if (n_match && (n_name_size > {8'd0, w_eff_len})) begin
                    if (n_file_size == 32'd0) begin
                        n_phase    = PH_DONE;
                        w_res_v    = 1'b1;
                        w_res.kind = KIND_EMPTY;
                        w_res.last = 1'b1;
                    end else begin
                        n_brem  = {1'b0, n_file_size};
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_brem  = w_skip;
                    n_phase = (w_skip == 33'd0) ? PH_HEADER : PH_SKIP;
                end
            end
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hcount    <= 5'd0;
            r_magic     <= 16'd0;
            r_name_size <= 16'd0;
            r_file_size <= 32'd0;
            r_name_pos  <= 16'd0;
            r_match     <= 1'b1;
            r_brem      <= 33'd0;
        end else begin
            r_phase     <= n_phase;
            r_hcount    <= n_hcount;
            r_magic     <= n_magic;
            r_name_size <= n_name_size;
            r_file_size <= n_file_size;
            r_name_pos  <= n_name_pos;
            r_match     <= n_match;
            r_brem      <= n_brem;
        end
    end

    // result beats
    cpio_bme_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_res_v),
        .i_res    (w_res),
        .o_ready  (w_in_ready),
        .o_result (o_result)
    );

endmodule
